>>> src/ppl_pkg.sv
package ppl_pkg;

   // Default coordinate width and the fixed register widths.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int TOL_WIDTH       = 23;
   localparam int TOL_SQ_WIDTH    = 2 * TOL_WIDTH;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 23'd128;

   // Configuration port.
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;
   localparam logic REG_TOLERANCE = 1'b0;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Axes and the three difference vectors carried per word.
   localparam int AXES      = 3;
   localparam int DIFF_SETS = 3;

   // Chunk width of the long shift-add multiplier.
   localparam int MUL_CHUNK = 16;

   // Last count of the short-product phase, which forms four sums.
   localparam int PROD_LAST = 4;

   // What the back has to do with one word.
   typedef enum logic [1:0] {
      KIND_OPEN,
      KIND_SINGLE,
      KIND_SEGMENT
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
   } ctrl_type;

   localparam int CTRL_W = $bits(ctrl_type);

   // The four dot products formed per word.
   typedef enum logic [1:0] {
      SUM_LEN,
      SUM_PROJ,
      SUM_WW,
      SUM_UU
   } sum_sel_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PROD,
      BK_DECIDE,
      BK_BIG1,
      BK_BIG2,
      BK_FINISH
   } back_state_type;

endpackage

>>> src/ppl_if.sv
// Path vertex channel.
interface ppl_req_if #(
   parameter int COORD_WIDTH = ppl_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;
   logic signed [COORD_WIDTH-1:0] query_z;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;
   logic                          first_vertex;
   logic                          last_vertex;

   modport source (
      output valid, query_x, query_y, query_z, vertex_x, vertex_y, vertex_z,
             first_vertex, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, query_x, query_y, query_z, vertex_x, vertex_y, vertex_z,
             first_vertex, last_vertex,
      output ready
   );
endinterface

// Near flag channel.
interface ppl_rsp_if;
   logic valid;
   logic ready;
   logic near;

   modport source (output valid, near, input ready);
   modport sink (input valid, near, output ready);
endinterface

>>> src/ppl_front.sv
module ppl_front #(
   parameter int COORD_WIDTH = ppl_pkg::COORD_WIDTH_DEF,
   parameter int DATA_W = ppl_pkg::CTRL_W
                          + ppl_pkg::DIFF_SETS * ppl_pkg::AXES * (COORD_WIDTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   ppl_req_if.sink                    req_ch,
   input  ppl_pkg::queue_status_type  q_stat,
   output logic                       push,
   output logic [DATA_W-1:0]          wr_data
);

   localparam int DW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] prev_ff [ppl_pkg::AXES];
   logic signed [COORD_WIDTH-1:0] prev_in [ppl_pkg::AXES];
   logic signed [COORD_WIDTH-1:0] q_v     [ppl_pkg::AXES];
   logic signed [COORD_WIDTH-1:0] v_v     [ppl_pkg::AXES];
   logic signed [DW-1:0]          d_v     [ppl_pkg::AXES];
   logic signed [DW-1:0]          w_v     [ppl_pkg::AXES];
   logic signed [DW-1:0]          u_v     [ppl_pkg::AXES];
   ppl_pkg::ctrl_type             ctrl;

   // A word is taken whenever the queue has room.
   assign req_ch.ready = ~q_stat.full;
   assign push = req_ch.valid & ~q_stat.full;

   assign q_v[0] = req_ch.query_x;
   assign q_v[1] = req_ch.query_y;
   assign q_v[2] = req_ch.query_z;
   assign v_v[0] = req_ch.vertex_x;
   assign v_v[1] = req_ch.vertex_y;
   assign v_v[2] = req_ch.vertex_z;

   // Segment direction, query offset from the segment start and from its end.
   always_comb begin
      for (int i = 0; i < ppl_pkg::AXES; i++) begin
         d_v[i] = DW'(v_v[i]) - DW'(prev_ff[i]);
         w_v[i] = DW'(q_v[i]) - DW'(prev_ff[i]);
         u_v[i] = DW'(q_v[i]) - DW'(v_v[i]);
      end
   end

   // Classify the word by its path marks.
   always_comb begin
      ctrl.last = req_ch.last_vertex;
      priority if (req_ch.first_vertex && req_ch.last_vertex) begin
         ctrl.kind = ppl_pkg::KIND_SINGLE;
      end else if (req_ch.first_vertex) begin
         ctrl.kind = ppl_pkg::KIND_OPEN;
      end else begin
         ctrl.kind = ppl_pkg::KIND_SEGMENT;
      end
   end

   assign wr_data = {ctrl, u_v[2], u_v[1], u_v[0], w_v[2], w_v[1], w_v[0],
                     d_v[2], d_v[1], d_v[0]};

   // The vertex of every accepted word starts the next segment.
   always_comb begin
      for (int i = 0; i < ppl_pkg::AXES; i++) begin
         prev_in[i] = push ? v_v[i] : prev_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ppl_pkg::AXES; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

>>> src/ppl_queue.sv
module ppl_queue #(
   parameter int DATA_W      = 8,
   parameter int QUEUE_DEPTH = ppl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      pop,
   output logic [DATA_W-1:0]         rd_data,
   output ppl_pkg::queue_status_type q_stat
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_data = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/ppl_back.sv
module ppl_back #(
   parameter int COORD_WIDTH = ppl_pkg::COORD_WIDTH_DEF,
   parameter int DATA_W = ppl_pkg::CTRL_W
                          + ppl_pkg::DIFF_SETS * ppl_pkg::AXES * (COORD_WIDTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [DATA_W-1:0]                rd_data,
   input  ppl_pkg::queue_status_type        q_stat,
   input  logic [ppl_pkg::TOL_SQ_WIDTH-1:0] tol_sq,
   output logic                             pop,
   ppl_rsp_if.source                        rsp_ch
);

   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = 2 * DW;                 // one short product
   localparam int SUM_W = PW + 2;                 // sum of three products
   localparam int P     = PW;                     // long multiplier operand width
   localparam int CMP_W = (SUM_W > ppl_pkg::TOL_SQ_WIDTH + 1)
                          ? SUM_W : ppl_pkg::TOL_SQ_WIDTH + 1;
   localparam int CH    = ppl_pkg::MUL_CHUNK;
   localparam int NCH   = (P + CH - 1) / CH;
   localparam int BW    = NCH * CH;
   localparam int ACC_W = P + BW;
   localparam int CNT_MAX = (NCH > ppl_pkg::PROD_LAST + 1) ? NCH : ppl_pkg::PROD_LAST + 1;
   localparam int CNT_W = $clog2(CNT_MAX);

   ppl_pkg::back_state_type state_ff, state_in;
   ppl_pkg::ctrl_type       ctrl;
   ppl_pkg::sum_sel_type    step, slot;

   logic [CNT_W-1:0]       cnt_ff, cnt_in, cnt_m1;
   logic signed [DW-1:0]   d_v [ppl_pkg::AXES];
   logic signed [DW-1:0]   w_v [ppl_pkg::AXES];
   logic signed [DW-1:0]   u_v [ppl_pkg::AXES];
   logic signed [DW-1:0]   opa [ppl_pkg::AXES];
   logic signed [DW-1:0]   opb [ppl_pkg::AXES];
   logic signed [PW-1:0]   prod_ff [ppl_pkg::AXES];
   logic signed [PW-1:0]   prod_in [ppl_pkg::AXES];
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [SUM_W-1:0] sum_val;
   logic                   sum_we;

   logic signed [CMP_W-1:0] len_c, proj_c, ww_c, uu_c, tol_c, e_c;
   logic                   len_zero, proj_pos, proj_ge, ww_lt, uu_lt;
   logic                   go_big, decide_hit;

   logic [P-1:0]           a_ff, a_in;
   logic [BW-1:0]          b_ff, b_in;
   logic [ACC_W-1:0]       acc_ff, acc_in, acc_step, big1_ff, big1_in;
   logic [P+CH-1:0]        part;
   logic                   hit_ff, hit_in, big_ff, big_in;
   logic                   found_ff, found_in, new_found, hit_now, finish_ok;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_near_ff, rsp_near_in;

   // Unpack the queue head.
   always_comb begin
      ctrl = ppl_pkg::ctrl_type'(rd_data[DATA_W-1 -: ppl_pkg::CTRL_W]);
      for (int i = 0; i < ppl_pkg::AXES; i++) begin
         d_v[i] = rd_data[i * DW +: DW];
         w_v[i] = rd_data[(ppl_pkg::AXES + i) * DW +: DW];
         u_v[i] = rd_data[(2 * ppl_pkg::AXES + i) * DW +: DW];
      end
   end

   // Short products: one multiplier per axis, one dot product per cycle.
   assign step   = ppl_pkg::sum_sel_type'(cnt_ff[1:0]);
   assign cnt_m1 = cnt_ff - 1'b1;
   assign slot   = ppl_pkg::sum_sel_type'(cnt_m1[1:0]);

   always_comb begin
      for (int i = 0; i < ppl_pkg::AXES; i++) begin
         unique case (step)
            ppl_pkg::SUM_LEN: begin
               opa[i] = d_v[i];
               opb[i] = d_v[i];
            end
            ppl_pkg::SUM_PROJ: begin
               opa[i] = w_v[i];
               opb[i] = d_v[i];
            end
            ppl_pkg::SUM_WW: begin
               opa[i] = w_v[i];
               opb[i] = w_v[i];
            end
            ppl_pkg::SUM_UU: begin
               opa[i] = u_v[i];
               opb[i] = u_v[i];
            end
            default: begin
               opa[i] = d_v[i];
               opb[i] = d_v[i];
            end
         endcase
         prod_in[i] = opa[i] * opb[i];
      end
   end

   // Adder behind the product registers.
   assign sum_val = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);

   // Clamp decision on the four dot products.
   always_comb begin
      len_c  = CMP_W'(sum_ff[ppl_pkg::SUM_LEN]);
      proj_c = CMP_W'(sum_ff[ppl_pkg::SUM_PROJ]);
      ww_c   = CMP_W'(sum_ff[ppl_pkg::SUM_WW]);
      uu_c   = CMP_W'(sum_ff[ppl_pkg::SUM_UU]);
      tol_c  = CMP_W'(tol_sq);
      e_c    = ww_c - tol_c;
      len_zero = (len_c == '0);
      proj_pos = (proj_c > 0);
      proj_ge  = (proj_c >= len_c);
      ww_lt    = (ww_c < tol_c);
      uu_lt    = (uu_c < tol_c);
      go_big     = 1'b0;
      decide_hit = 1'b0;
      priority if (ctrl.kind == ppl_pkg::KIND_SINGLE) begin
         decide_hit = uu_lt;
      end else if (ctrl.kind != ppl_pkg::KIND_SEGMENT) begin
         decide_hit = 1'b0;
      end else if (len_zero) begin
         decide_hit = 1'b0;
      end else if (!proj_pos) begin
         decide_hit = ww_lt;
      end else if (proj_ge) begin
         decide_hit = uu_lt;
      end else if (ww_lt) begin
         decide_hit = 1'b1;
      end else begin
         go_big = 1'b1;
      end
   end

   // Long shift-add multiplier, one chunk of the second operand per cycle.
   assign part     = a_ff * b_ff[BW-1 -: CH];
   assign acc_step = {acc_ff[ACC_W-CH-1:0], {CH{1'b0}}} + ACC_W'(part);

   // Interior case: (ww - tol^2) * len^2 < proj^2.
   assign hit_now   = big_ff ? (big1_ff < acc_ff) : hit_ff;
   assign finish_ok = ~ctrl.last | ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      unique case (ctrl.kind)
         ppl_pkg::KIND_OPEN:    new_found = 1'b0;
         ppl_pkg::KIND_SINGLE:  new_found = hit_now;
         ppl_pkg::KIND_SEGMENT: new_found = found_ff | hit_now;
         default:               new_found = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppl_pkg::BK_IDLE: begin
            if (!q_stat.empty) state_in = ppl_pkg::BK_PROD;
         end
         ppl_pkg::BK_PROD: begin
            if (cnt_ff == CNT_W'(ppl_pkg::PROD_LAST)) state_in = ppl_pkg::BK_DECIDE;
         end
         ppl_pkg::BK_DECIDE: begin
            state_in = go_big ? ppl_pkg::BK_BIG1 : ppl_pkg::BK_FINISH;
         end
         ppl_pkg::BK_BIG1: begin
            if (cnt_ff == CNT_W'(NCH - 1)) state_in = ppl_pkg::BK_BIG2;
         end
         ppl_pkg::BK_BIG2: begin
            if (cnt_ff == CNT_W'(NCH - 1)) state_in = ppl_pkg::BK_FINISH;
         end
         ppl_pkg::BK_FINISH: begin
            if (finish_ok) state_in = ppl_pkg::BK_IDLE;
         end
         default: state_in = ppl_pkg::BK_IDLE;
      endcase
   end

   // Datapath controls and register updates per state.
   always_comb begin
      cnt_in       = cnt_ff;
      sum_we       = 1'b0;
      hit_in       = hit_ff;
      big_in       = big_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      big1_in      = big1_ff;
      found_in     = found_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_near_in  = rsp_near_ff;
      unique case (state_ff)
         ppl_pkg::BK_IDLE: begin
            cnt_in = '0;
         end
         ppl_pkg::BK_PROD: begin
            sum_we = (cnt_ff != '0);
            cnt_in = (cnt_ff == CNT_W'(ppl_pkg::PROD_LAST)) ? '0 : cnt_ff + 1'b1;
         end
         ppl_pkg::BK_DECIDE: begin
            hit_in = decide_hit;
            big_in = go_big;
            a_in   = e_c[P-1:0];
            b_in   = BW'(len_c[P-1:0]);
            acc_in = '0;
            cnt_in = '0;
         end
         ppl_pkg::BK_BIG1: begin
            acc_in = acc_step;
            b_in   = {b_ff[BW-CH-1:0], {CH{1'b0}}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NCH - 1)) begin
               big1_in = acc_step;
               acc_in  = '0;
               a_in    = proj_c[P-1:0];
               b_in    = BW'(proj_c[P-1:0]);
               cnt_in  = '0;
            end
         end
         ppl_pkg::BK_BIG2: begin
            acc_in = acc_step;
            b_in   = {b_ff[BW-CH-1:0], {CH{1'b0}}};
            cnt_in = (cnt_ff == CNT_W'(NCH - 1)) ? '0 : cnt_ff + 1'b1;
         end
         ppl_pkg::BK_FINISH: begin
            if (finish_ok) begin
               pop = 1'b1;
               if (ctrl.last) begin
                  found_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_near_in  = new_found;
               end else begin
                  found_in = new_found;
               end
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.near  = rsp_near_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppl_pkg::BK_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         big_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         big_ff       <= big_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      hit_ff      <= hit_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      big1_ff     <= big1_in;
      rsp_near_ff <= rsp_near_in;
      if (sum_we) begin
         sum_ff[slot] <= sum_val;
      end
   end

endmodule

>>> src/point_near_polyline_test.sv
// Channel  Dir  Word                                          Handshake
// req_ch   in   query xyz, vertex xyz, first/last marks       valid/ready
// rsp_ch   out  near flag, one per path                       valid/ready
// csr      in   tolerance at byte 0 (APB write, read back)    psel/penable
//
// The front takes a vertex in any cycle the two-entry queue has room.
// The back takes one vertex at a time through a start step, a product phase
// for the three per-axis multipliers and their adder, the clamp decision and
// a finish step. An interior projection adds two passes of the 16-bit-chunk
// long multiplier. Reset is synchronous; tolerance returns to 128. On a last
// vertex, a pending result holds the back at its finish step until rsp_ch
// takes it.
module point_near_polyline_test #(
   parameter int COORD_WIDTH = ppl_pkg::COORD_WIDTH_DEF,
   parameter int QUEUE_DEPTH = ppl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ppl_req_if.sink                         req_ch,
   ppl_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ppl_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [ppl_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [ppl_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int DATA_W = ppl_pkg::CTRL_W
                           + ppl_pkg::DIFF_SETS * ppl_pkg::AXES * (COORD_WIDTH + 1);

   logic [ppl_pkg::TOL_WIDTH-1:0]    tolerance_ff, tolerance_in;
   logic [ppl_pkg::TOL_SQ_WIDTH-1:0] tol_sq_ff, tol_sq_in;
   logic                             csr_write;
   logic                             push, pop;
   logic [DATA_W-1:0]                wr_data, rd_data;
   ppl_pkg::queue_status_type        q_stat;

   // Register port: the tolerance and its square are updated together.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr[2] == ppl_pkg::REG_TOLERANCE);
   assign tolerance_in = csr_write ? pwdata[ppl_pkg::TOL_WIDTH-1:0] : tolerance_ff;
   assign tol_sq_in    = csr_write ? ppl_pkg::TOL_SQ_WIDTH'(tolerance_in)
                                     * ppl_pkg::TOL_SQ_WIDTH'(tolerance_in)
                                   : tol_sq_ff;

   always_comb begin
      if (paddr[2] == ppl_pkg::REG_TOLERANCE) begin
         prdata = ppl_pkg::APB_DATA_W'(tolerance_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= ppl_pkg::TOL_RESET;
         tol_sq_ff    <= ppl_pkg::TOL_SQ_WIDTH'(ppl_pkg::TOL_RESET)
                         * ppl_pkg::TOL_SQ_WIDTH'(ppl_pkg::TOL_RESET);
      end else begin
         tolerance_ff <= tolerance_in;
         tol_sq_ff    <= tol_sq_in;
      end
   end

   ppl_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .DATA_W     (DATA_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_stat (q_stat),
      .push   (push),
      .wr_data(wr_data)
   );

   ppl_queue #(
      .DATA_W     (DATA_W),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_data(wr_data),
      .pop    (pop),
      .rd_data(rd_data),
      .q_stat (q_stat)
   );

   ppl_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .DATA_W     (DATA_W)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .rd_data(rd_data),
      .q_stat (q_stat),
      .tol_sq (tol_sq_ff),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // A full queue must hold off the input channel.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_ch.ready)
      else $error("input accepted while the queue is full");

   // The back never takes a word from an empty queue.
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // The squared tolerance tracks the tolerance register.
   a_tol_sq: assert property (@(posedge clock) disable iff (reset)
      tol_sq_ff == ppl_pkg::TOL_SQ_WIDTH'(tolerance_ff)
                   * ppl_pkg::TOL_SQ_WIDTH'(tolerance_ff))
      else $error("squared tolerance out of step with tolerance");

endmodule

>>> tb/tb_point_near_polyline_test.sv
module tb_point_near_polyline_test;

   localparam int CW           = ppl_pkg::COORD_WIDTH_DEF;
   localparam int MAXC         = 8388607;
   localparam int MINC         = -8388608;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 250;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int TIMEOUT      = 5000000;
   localparam logic [ppl_pkg::APB_ADDR_W-1:0] TOL_ADDR =
      ppl_pkg::APB_ADDR_W'(4 * ppl_pkg::REG_TOLERANCE);

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [127:0]   wide_type;

   typedef struct {
      coord_type query_x, query_y, query_z;
      coord_type vertex_x, vertex_y, vertex_z;
      bit        first_vertex, last_vertex;
   } vertex_word_type;

   // Tracks the path state and the near flags that are still to come.
   class near_scoreboard;
      coord_type                     prev_x, prev_y, prev_z;
      bit                            found;
      logic [ppl_pkg::TOL_WIDTH-1:0] tolerance;
      bit                            near_queue[$];
      int                            errors, words, paths, near_paths, settings;

      function new();
         prev_x     = '0;
         prev_y     = '0;
         prev_z     = '0;
         found      = 1'b0;
         tolerance  = ppl_pkg::TOL_RESET;
         errors     = 0;
         words      = 0;
         paths      = 0;
         near_paths = 0;
         settings   = 0;
      endfunction

      function void set_tolerance(input logic [ppl_pkg::TOL_WIDTH-1:0] value);
         tolerance = value;
         settings++;
      endfunction

      static function wide_type dot3(input wide_type ax, ay, az, bx, by, bz);
         return ax * bx + ay * by + az * bz;
      endfunction

      // Squared distance to the segment from the held vertex, clamped at both ends.
      // Interior points compare |w|^2*|d|^2 - (w.d)^2 with tol^2*|d|^2.
      function bit segment_within(input wide_type qx, qy, qz, vx, vy, vz, tol_sq);
         wide_type px, py, pz, dx, dy, dz, wx, wy, wz, len_sq, proj, w_sq;
         px = prev_x;
         py = prev_y;
         pz = prev_z;
         dx = vx - px;
         dy = vy - py;
         dz = vz - pz;
         wx = qx - px;
         wy = qy - py;
         wz = qz - pz;
         len_sq = dot3(dx, dy, dz, dx, dy, dz);
         if (len_sq <= 0) return 1'b0;
         proj = dot3(wx, wy, wz, dx, dy, dz);
         w_sq = dot3(wx, wy, wz, wx, wy, wz);
         if (proj <= 0) return w_sq < tol_sq;
         if (proj >= len_sq)
            return dot3(qx - vx, qy - vy, qz - vz, qx - vx, qy - vy, qz - vz) < tol_sq;
         return w_sq * len_sq - proj * proj < tol_sq * len_sq;
      endfunction

      // Called for every accepted vertex word.
      function void note_vertex(input vertex_word_type w);
         wide_type qx, qy, qz, vx, vy, vz, tol_w, tol_sq;
         qx = w.query_x;
         qy = w.query_y;
         qz = w.query_z;
         vx = w.vertex_x;
         vy = w.vertex_y;
         vz = w.vertex_z;
         tol_w  = tolerance;
         tol_sq = tol_w * tol_w;
         if (w.first_vertex) begin
            found = 1'b0;
            if (w.last_vertex)
               found = dot3(qx - vx, qy - vy, qz - vz, qx - vx, qy - vy, qz - vz) < tol_sq;
         end else if (segment_within(qx, qy, qz, vx, vy, vz, tol_sq)) begin
            found = 1'b1;
         end
         prev_x = w.vertex_x;
         prev_y = w.vertex_y;
         prev_z = w.vertex_z;
         words++;
         if (w.last_vertex) begin
            near_queue.insert(near_queue.size(), found);
            found = 1'b0;
         end
      endfunction

      // Called for every accepted result word.
      function void check_near(input logic actual);
         bit want;
         if (near_queue.size() == 0) begin
            errors++;
            $error("near: result with no path pending, expected none, actual %0b", actual);
            return;
         end
         want = near_queue.pop_front();
         paths++;
         if (want) near_paths++;
         if (actual !== want) begin
            errors++;
            $error("near: expected %0b, actual %0b", want, actual);
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [ppl_pkg::APB_ADDR_W-1:0] paddr;
   logic [ppl_pkg::APB_DATA_W-1:0] pwdata;
   logic [ppl_pkg::APB_DATA_W-1:0] prdata;
   logic                           pready;

   bit steady;
   bit pressure_go;
   int csr_errors;

   near_scoreboard board = new();

   ppl_req_if #(.COORD_WIDTH(CW)) req_ch ();
   ppl_rsp_if                     rsp_ch ();

   point_near_polyline_test #(.COORD_WIDTH(CW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Random signed value in [-2^k, 2^k - 1]; k = 23 spans the whole field.
   function automatic int rand_coord(input int k);
      return int'($urandom_range(0, (32'd1 << (k + 1)) - 1)) - (1 << k);
   endfunction

   // Offers one vertex word, with an occasional idle burst first, and waits for
   // the handshake. Starts and ends at a falling edge.
   task automatic send_vertex(input int qx, qy, qz, vx, vy, vz, input bit first, last);
      vertex_word_type w;
      int gap;
      w.query_x      = CW'(qx);
      w.query_y      = CW'(qy);
      w.query_z      = CW'(qz);
      w.vertex_x     = CW'(vx);
      w.vertex_y     = CW'(vy);
      w.vertex_z     = CW'(vz);
      w.first_vertex = first;
      w.last_vertex  = last;
      if (!steady && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 3);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.query_x      <= w.query_x;
      req_ch.query_y      <= w.query_y;
      req_ch.query_z      <= w.query_z;
      req_ch.vertex_x     <= w.vertex_x;
      req_ch.vertex_y     <= w.vertex_y;
      req_ch.vertex_z     <= w.vertex_z;
      req_ch.first_vertex <= w.first_vertex;
      req_ch.last_vertex  <= w.last_vertex;
      do @(posedge clock); while (!req_ch.ready);
      board.note_vertex(w);
      @(negedge clock);
   endtask

   // One APB transfer on the tolerance register. A write updates the model;
   // a read is compared with the value the model holds.
   task automatic tolerance_access(input bit do_write,
                                   input logic [ppl_pkg::TOL_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= do_write;
      paddr   <= TOL_ADDR;
      pwdata  <= ppl_pkg::APB_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (do_write) begin
         board.set_tolerance(value);
      end else if (prdata !== ppl_pkg::APB_DATA_W'(board.tolerance)) begin
         csr_errors++;
         $error("tolerance: expected %0d, actual %0d", board.tolerance, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering, waits for every pending near flag, then lets the back
   // finish any vertex that produces no result.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.near_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Hand-picked paths at the reset tolerance of 0.5 m.
   task automatic directed_paths();
      // Vertices before any first mark extend from the reset vertex at the origin.
      send_vertex(0, 0, 0, 256, 0, 0, 1'b0, 1'b0);
      send_vertex(10000, 10000, 10000, 512, 0, 0, 1'b0, 1'b1);
      // Single-vertex paths: inside, on the boundary, and at the field extremes.
      send_vertex(100, 0, 0, 0, 0, 0, 1'b1, 1'b1);
      send_vertex(128, 0, 0, 0, 0, 0, 1'b1, 1'b1);
      send_vertex(MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b1, 1'b1);
      send_vertex(MINC, MINC, MINC, MINC, MINC, MINC, 1'b1, 1'b1);
      // A path made only of a zero-length segment answers false.
      send_vertex(5, 5, 5, 5, 5, 5, 1'b1, 1'b0);
      send_vertex(5, 5, 5, 5, 5, 5, 1'b0, 1'b1);
      // Interior projection, just inside and exactly on the tolerance.
      send_vertex(0, 100, 0, -1000, 0, 0, 1'b1, 1'b0);
      send_vertex(0, 100, 0, 1000, 0, 0, 1'b0, 1'b1);
      send_vertex(0, 128, 0, -1000, 0, 0, 1'b1, 1'b0);
      send_vertex(0, 128, 0, 1000, 0, 0, 1'b0, 1'b1);
      // Projection clamped past the far end.
      send_vertex(1100, 0, 0, 0, 0, 0, 1'b1, 1'b0);
      send_vertex(1100, 0, 0, 1000, 0, 0, 1'b0, 1'b1);
      // Query moves inside the path; only the first segment sees it close.
      send_vertex(9000, 9000, 9000, 0, 0, 0, 1'b1, 1'b0);
      send_vertex(500, 50, 0, 1000, 0, 0, 1'b0, 1'b0);
      send_vertex(9000, 9000, 9000, 1000, 1000, 0, 1'b0, 1'b0);
      send_vertex(9000, 9000, 9000, 2000, 1000, 0, 1'b0, 1'b1);
      // Longest possible segment, with the query near and far from it.
      send_vertex(0, 0, 0, MINC, MINC, MINC, 1'b1, 1'b0);
      send_vertex(0, 0, 0, MAXC, MAXC, MAXC, 1'b0, 1'b1);
      send_vertex(MAXC, MINC, 0, MINC, MINC, MINC, 1'b1, 1'b0);
      send_vertex(MAXC, MINC, 0, MAXC, MAXC, MAXC, 1'b0, 1'b1);
      // Zero-length segment followed by a real one, clamped before its start.
      send_vertex(0, -50, 0, 0, 0, 0, 1'b1, 1'b0);
      send_vertex(0, -50, 0, 0, 0, 0, 1'b0, 1'b0);
      send_vertex(0, -50, 0, 0, 400, 0, 1'b0, 1'b1);
   endtask

   // Mostly well-formed paths clustered around their query point, some paths cut
   // short, and some words with random content and random marks.
   task automatic random_paths(input int count);
      int sent, len, span, reach;
      int qx, qy, qz, vx, vy, vz;
      bit cut;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_vertex(rand_coord(23), rand_coord(23), rand_coord(23),
                        rand_coord(23), rand_coord(23), rand_coord(23),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
            span = ($urandom_range(0, 2) == 0) ? 23 : $urandom_range(4, 14);
            cut  = ($urandom_range(0, 19) == 0);
            qx = rand_coord(span);
            qy = rand_coord(span);
            qz = rand_coord(span);
            vx = 0;
            vy = 0;
            vz = 0;
            for (int i = 0; i < len; i++) begin
               if (i > 0 && $urandom_range(0, 5) == 0) begin
                  reach = $urandom_range(0, span);
                  qx = qx + rand_coord(reach);
                  qy = qy + rand_coord(reach);
                  qz = qz + rand_coord(reach);
               end
               // Now and then the vertex repeats, closing a zero-length segment.
               if (i == 0 || $urandom_range(0, 7) != 0) begin
                  reach = $urandom_range(0, span);
                  vx = qx + rand_coord(reach);
                  vy = qy + rand_coord(reach);
                  vz = qz + rand_coord(reach);
               end
               send_vertex(qx, qy, qz, vx, vy, vz, i == 0, i == len - 1 && !cut);
            end
            sent += len;
         end
      end
   endtask

   // Result side: random ready bursts, one long hold on request, checks at the
   // rising edge.
   initial begin : result_sink
      int gap_left;
      bit pressure_done;
      gap_left      = 0;
      pressure_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            gap_left      = HOLD_CYCLES;
         end else if (gap_left == 0 && !steady && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 3);
         end
         if (gap_left > 0) begin
            rsp_ch.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_near(rsp_ch.near);
      end
   end

   // Overall limit on the run.
   initial begin : watchdog
      #TIMEOUT;
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence: reset, directed paths, then random phases over a range of
   // tolerances, the last one without idling.
   initial begin : main_flow
      logic [ppl_pkg::TOL_WIDTH-1:0] tol_plan[PHASES];
      int total_errors;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.query_x      <= '0;
      req_ch.query_y      <= '0;
      req_ch.query_z      <= '0;
      req_ch.vertex_x     <= '0;
      req_ch.vertex_y     <= '0;
      req_ch.vertex_z     <= '0;
      req_ch.first_vertex <= 1'b0;
      req_ch.last_vertex  <= 1'b0;
      steady      = 1'b0;
      pressure_go = 1'b0;
      csr_errors  = 0;
      tol_plan[0] = '0;
      tol_plan[1] = '1;
      tol_plan[2] = 23'd256;
      tol_plan[3] = ppl_pkg::TOL_WIDTH'($urandom_range(1, 4096));
      tol_plan[4] = ppl_pkg::TOL_WIDTH'($urandom_range(0, MAXC));
      tol_plan[5] = ppl_pkg::TOL_WIDTH'($urandom_range(1, 65535));
      tol_plan[6] = 23'd1;
      tol_plan[7] = ppl_pkg::TOL_WIDTH'($urandom_range(16, 2048));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tolerance_access(1'b0, '0);
      directed_paths();
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         tolerance_access(1'b1, tol_plan[p]);
         tolerance_access(1'b0, '0);
         if (p == 2) pressure_go = 1'b1;
         if (p == PHASES - 1) steady = 1'b1;
         random_paths(PHASE_WORDS);
         drain_results();
      end

      total_errors = board.errors + csr_errors;
      $display("Run covered %0d vertex words and %0d path results, %0d of them near,",
               board.words, board.paths, board.near_paths);
      $display("over %0d tolerance settings from zero to full scale.", board.settings + 1);
      if (total_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
